@@ hw/rtl/mips_subset_execute_unit_macros.svh @@
// Assertion macros shared by the execute unit RTL
`ifndef MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define MSEU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSEU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mseu_pkg.sv @@
// Package: opcodes, status codes and shared types of the execute unit
`default_nettype none
package mseu_pkg;
    localparam int unsigned MEM_WORDS_DEF = 1024;
    localparam int unsigned NUM_REGS      = 32;
    localparam int unsigned XLEN          = 32;

    localparam logic [3:0] OP_ADDI = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_AND  = 4'd3;
    localparam logic [3:0] OP_OR   = 4'd4;
    localparam logic [3:0] OP_XOR  = 4'd5;
    localparam logic [3:0] OP_SLT  = 4'd6;
    localparam logic [3:0] OP_SLL  = 4'd7;
    localparam logic [3:0] OP_SRL  = 4'd8;
    localparam logic [3:0] OP_LW   = 4'd9;
    localparam logic [3:0] OP_SW   = 4'd10;
    localparam logic [3:0] OP_MULT = 4'd11;
    localparam logic [3:0] OP_DIV  = 4'd12;
    localparam logic [3:0] OP_MFHI = 4'd13;
    localparam logic [3:0] OP_MFLO = 4'd14;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_ADDR = 2'd2;

    // request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;
endpackage
`default_nettype wire

@@ hw/rtl/mseu_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module mseu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/mseu_muldiv.sv @@
// Iterative signed multiply / divide sharing one 33-bit adder
`default_nettype none
module mseu_muldiv (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mseu_pkg::t_md_req i_req,
    input  wire logic [31:0]      i_a,
    input  wire logic [31:0]      i_b,
    output logic                  o_done,
    output logic [31:0]           o_hi,
    output logic [31:0]           o_lo
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_FIX  = 2'd2;

    logic [1:0]  r_phase;
    logic [4:0]  r_cnt;
    logic        r_div, r_neg_q, r_neg_r;
    logic [31:0] r_hi, r_lo, r_mb;
    logic        r_done;

    logic [31:0] ma, mb;
    logic [32:0] opx, opy;
    logic [33:0] sum;
    logic [63:0] prod_neg;

    assign ma = i_a[31] ? (32'd0 - i_a) : i_a;
    assign mb = i_b[31] ? (32'd0 - i_b) : i_b;

    // divide: trial subtract of the shifted remainder; multiply: conditional add
    always_comb begin
        if (r_div) begin
            opx = {r_hi, r_lo[31]};
            opy = ~{1'b0, r_mb};
        end else begin
            opx = {1'b0, r_hi};
            opy = r_lo[0] ? {1'b0, r_mb} : 33'd0;
        end
        sum = {1'b0, opx} + {1'b0, opy} + {33'd0, r_div};
    end

    assign prod_neg = 64'd0 - {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= PH_RUN;
                        r_cnt   <= '0;
                        r_div   <= i_req.is_div;
                        r_hi    <= '0;
                        r_lo    <= ma;
                        r_mb    <= mb;
                        r_neg_q <= i_a[31] ^ i_b[31];
                        r_neg_r <= i_a[31];
                    end
                end
                PH_RUN: begin
                    if (r_div) begin
                        r_hi <= sum[33] ? sum[31:0] : opx[31:0];
                        r_lo <= {r_lo[30:0], sum[33]};
                    end else begin
                        r_hi <= sum[32:1];
                        r_lo <= {sum[0], r_lo[31:1]};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_phase <= PH_FIX;
                    end
                end
                PH_FIX: begin
                    if (r_div) begin
                        if (r_neg_q) r_lo <= 32'd0 - r_lo;
                        if (r_neg_r) r_hi <= 32'd0 - r_hi;
                    end else if (r_neg_q) begin
                        r_hi <= prod_neg[63:32];
                        r_lo <= prod_neg[31:0];
                    end
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;
endmodule
`default_nettype wire

@@ hw/rtl/mips_subset_execute_unit.sv @@
// Top level: MIPS subset execute unit with register file, HI/LO and data memory
//
//  channel   dir  word bits (low to high)
//  s_axis    in   op[3:0] field_a[8:4] field_b[13:9] field_c[29:14], pad to 32
//  m_axis    out  reg_write, reg_index, reg_value, mem_write, hi, lo, status
//
// One instruction at a time. MULT and DIV run the 32 steps of the shared adder,
// which DIV skips for a zero divisor. After reset the data memory is cleared
// one word a cycle; s_axis_tready stays low meanwhile. A held result stalls
// the next instruction only at its final step; the next word is taken while a
// result waits.
`default_nettype none
`include "mips_subset_execute_unit_macros.svh"
module mips_subset_execute_unit #(
    parameter int unsigned MEM_WORDS = mseu_pkg::MEM_WORDS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op, field_a, field_b, field_c, zero pad
    input  wire logic [31:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // reg_write, reg_index, reg_value, mem_write, hi_value, lo_value, status, zero pad
    output logic [111:0]      m_axis_tdata
);
    localparam int unsigned AW = $clog2(MEM_WORDS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDB  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_LWD  = 3'd3;
    localparam logic [2:0] S_MD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  r_state;
    logic [3:0]  r_op;
    logic [4:0]  r_a, r_b;
    logic [15:0] r_c;
    logic [31:0] r_va;
    logic [31:0] r_hi, r_lo;
    logic [31:0] r_rf_vld;
    logic        r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic        r_res_wr, r_res_memw;
    logic [4:0]  r_res_idx;
    logic [31:0] r_res_val;
    logic [1:0]  r_res_st;

    logic         r_out_vld;
    logic [111:0] r_out;

    logic [31:0] rf_q, dm_q, vb, imm, addr_sum;
    logic [4:0]  rf_raddr;
    logic        addr_ok, out_free;
    logic        dm_we;
    logic [AW-1:0] dm_waddr;
    logic [31:0]   dm_wdata;
    mseu_pkg::t_md_req md_req;
    logic        md_done;
    logic [31:0] md_hi, md_lo;

    assign s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign out_free      = !r_out_vld || m_axis_tready;

    assign rf_raddr = (r_state == S_IDLE) ? s_axis_tdata[8:4] : r_b;
    assign vb       = (r_b != 5'd0 && r_rf_vld[r_b]) ? rf_q : 32'd0;
    assign imm      = {{16{r_c[15]}}, r_c};
    assign addr_sum = r_va + imm;
    assign addr_ok  = !addr_sum[31] && (addr_sum < 32'(MEM_WORDS));

    assign dm_we    = r_clr_busy || (r_state == S_EXEC && r_op == mseu_pkg::OP_SW && addr_ok);
    assign dm_waddr = r_clr_busy ? r_clr_addr : addr_sum[AW-1:0];
    assign dm_wdata = r_clr_busy ? 32'd0 : vb;

    assign md_req.start  = (r_state == S_EXEC) &&
                           (r_op == mseu_pkg::OP_MULT ||
                            (r_op == mseu_pkg::OP_DIV && vb != 32'd0));
    assign md_req.is_div = (r_op == mseu_pkg::OP_DIV);

    mseu_ram #(.WIDTH(32), .DEPTH(mseu_pkg::NUM_REGS)) u_rf (
        .i_clk   (i_clk),
        .i_we    (r_state == S_OUT && out_free && r_res_wr),
        .i_waddr (r_res_idx),
        .i_wdata (r_res_val),
        .i_raddr (rf_raddr),
        .o_rdata (rf_q)
    );

    mseu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (addr_sum[AW-1:0]),
        .o_rdata (dm_q)
    );

    mseu_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (r_va),
        .i_b     (vb),
        .o_done  (md_done),
        .o_hi    (md_hi),
        .o_lo    (md_lo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rf_vld   <= '0;
            r_hi       <= '0;
            r_lo       <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MEM_WORDS - 1)) r_clr_busy <= 1'b0;
            end
            if (r_state == S_OUT && out_free) r_out_vld <= 1'b1;
            else if (m_axis_tready)           r_out_vld <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= s_axis_tdata[3:0];
                        r_a     <= s_axis_tdata[8:4];
                        r_b     <= s_axis_tdata[13:9];
                        r_c     <= s_axis_tdata[29:14];
                        r_state <= S_RDB;
                    end
                end
                S_RDB: begin
                    r_va    <= (r_a != 5'd0 && r_rf_vld[r_a]) ? rf_q : 32'd0;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_res_wr   <= 1'b1;
                    r_res_idx  <= r_c[4:0];
                    r_res_val  <= 32'd0;
                    r_res_memw <= 1'b0;
                    r_res_st   <= mseu_pkg::ST_OK;
                    r_state    <= S_OUT;
                    case (r_op)
                        mseu_pkg::OP_ADDI: begin
                            r_res_idx <= r_b;
                            r_res_val <= addr_sum;
                        end
                        mseu_pkg::OP_ADD: r_res_val <= r_va + vb;
                        mseu_pkg::OP_SUB: r_res_val <= r_va - vb;
                        mseu_pkg::OP_AND: r_res_val <= r_va & vb;
                        mseu_pkg::OP_OR:  r_res_val <= r_va | vb;
                        mseu_pkg::OP_XOR: r_res_val <= r_va ^ vb;
                        mseu_pkg::OP_SLT: r_res_val <= {31'd0, $signed(r_va) < $signed(vb)};
                        mseu_pkg::OP_SLL: begin
                            r_res_idx <= r_b;
                            r_res_val <= r_va << r_c[4:0];
                        end
                        mseu_pkg::OP_SRL: begin
                            r_res_idx <= r_b;
                            r_res_val <= r_va >> r_c[4:0];
                        end
                        mseu_pkg::OP_LW: begin
                            r_res_idx <= r_b;
                            if (addr_ok) begin
                                r_state <= S_LWD;
                            end else begin
                                r_res_wr <= 1'b0;
                                r_res_st <= mseu_pkg::ST_ADDR;
                            end
                        end
                        mseu_pkg::OP_SW: begin
                            r_res_wr <= 1'b0;
                            if (addr_ok) r_res_memw <= 1'b1;
                            else         r_res_st   <= mseu_pkg::ST_ADDR;
                        end
                        mseu_pkg::OP_MULT: begin
                            r_res_wr <= 1'b0;
                            r_state  <= S_MD;
                        end
                        mseu_pkg::OP_DIV: begin
                            r_res_wr <= 1'b0;
                            if (vb == 32'd0) r_res_st <= mseu_pkg::ST_DIVZ;
                            else             r_state  <= S_MD;
                        end
                        mseu_pkg::OP_MFHI: begin
                            r_res_idx <= r_a;
                            r_res_val <= r_hi;
                        end
                        mseu_pkg::OP_MFLO: begin
                            r_res_idx <= r_a;
                            r_res_val <= r_lo;
                        end
                        default: r_res_wr <= 1'b0;
                    endcase
                end
                S_LWD: begin
                    r_res_val <= dm_q;
                    r_state   <= S_OUT;
                end
                S_MD: begin
                    if (md_done) begin
                        r_hi    <= md_hi;
                        r_lo    <= md_lo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        // writes to register zero are dropped and reported as none
                        if (r_res_wr && r_res_idx != 5'd0) begin
                            r_rf_vld[r_res_idx] <= 1'b1;
                            r_out <= {7'd0, r_res_st, r_lo, r_hi, r_res_memw,
                                      r_res_val, r_res_idx, 1'b1};
                        end else begin
                            r_out <= {7'd0, r_res_st, r_lo, r_hi, r_res_memw,
                                      32'd0, 5'd0, 1'b0};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    `MSEU_ASSERT_NOW(a_ready_idle, s_axis_tready, r_state == S_IDLE && !r_clr_busy, "ready outside idle")
    `MSEU_ASSERT_NOW(a_rzero, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[5:1] != 5'd0, "reg zero written")
    `MSEU_ASSERT_NEXT(a_md_hold, r_state == S_MD && !md_done, r_state == S_MD, "left mul/div early")
    `MSEU_ASSERT_NOW(a_rf0, 1'b1, !r_rf_vld[0], "register zero marked written")
endmodule
`default_nettype wire

@@ sim/mips_subset_execute_unit_test.sv @@
// Testbench for the MIPS subset execute unit: directed and random instruction streams
`default_nettype none
module mips_subset_execute_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MEMW = mseu_pkg::MEM_WORDS_DEF;
    localparam int unsigned WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        mem_write;
        logic [31:0] reg_value;
        logic [4:0]  reg_index;
        logic        reg_write;
    } t_exec_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // op[3:0], field_a[8:4], field_b[13:9], field_c[29:14]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;   // reg_write, reg_index, reg_value, mem_write, hi, lo, status

    mips_subset_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predicted architectural state
    logic [31:0] gpr [mseu_pkg::NUM_REGS];
    logic [31:0] hi_q, lo_q;
    logic [31:0] dmem [MEMW];

    t_exec_result pending_results[$];
    int  errors;
    int  idle_cycles;
    int  stall_left = 0;
    bit  quiet;   // no stalls in the closing stretch

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_exec_result execute_instr(logic [3:0] op, logic [4:0] fa,
                                                   logic [4:0] fb, logic [15:0] fc);
        t_exec_result r;
        logic [31:0] va, vb, imm, ea, q, rm, ma, mb;
        logic signed [63:0] prod;
        logic wr;
        logic [4:0] widx;
        logic [31:0] wval;
        r = '0;
        va = (fa == 0) ? 32'd0 : gpr[fa];
        vb = (fb == 0) ? 32'd0 : gpr[fb];
        imm = {{16{fc[15]}}, fc};
        ea = va + imm;
        wr = 1'b0; widx = 5'd0; wval = 32'd0;
        case (op)
            mseu_pkg::OP_ADDI: begin wr = 1; widx = fb;      wval = va + imm; end
            mseu_pkg::OP_ADD:  begin wr = 1; widx = fc[4:0]; wval = va + vb; end
            mseu_pkg::OP_SUB:  begin wr = 1; widx = fc[4:0]; wval = va - vb; end
            mseu_pkg::OP_AND:  begin wr = 1; widx = fc[4:0]; wval = va & vb; end
            mseu_pkg::OP_OR:   begin wr = 1; widx = fc[4:0]; wval = va | vb; end
            mseu_pkg::OP_XOR:  begin wr = 1; widx = fc[4:0]; wval = va ^ vb; end
            mseu_pkg::OP_SLT:  begin
                wr = 1; widx = fc[4:0];
                wval = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
            end
            mseu_pkg::OP_SLL:  begin wr = 1; widx = fb; wval = va << fc[4:0]; end
            mseu_pkg::OP_SRL:  begin wr = 1; widx = fb; wval = va >> fc[4:0]; end
            mseu_pkg::OP_LW: begin
                if (!ea[31] && ea < MEMW) begin
                    wr = 1; widx = fb; wval = dmem[ea];
                end else r.status = mseu_pkg::ST_ADDR;
            end
            mseu_pkg::OP_SW: begin
                if (!ea[31] && ea < MEMW) begin
                    dmem[ea] = vb; r.mem_write = 1'b1;
                end else r.status = mseu_pkg::ST_ADDR;
            end
            mseu_pkg::OP_MULT: begin
                prod = $signed({{32{va[31]}}, va}) * $signed({{32{vb[31]}}, vb});
                hi_q = prod[63:32]; lo_q = prod[31:0];
            end
            mseu_pkg::OP_DIV: begin
                if (vb == 0) r.status = mseu_pkg::ST_DIVZ;
                else begin
                    ma = va[31] ? -va : va;
                    mb = vb[31] ? -vb : vb;
                    q = ma / mb; rm = ma % mb;
                    lo_q = (va[31] != vb[31]) ? -q : q;
                    hi_q = va[31] ? -rm : rm;
                end
            end
            mseu_pkg::OP_MFHI: begin wr = 1; widx = fa; wval = hi_q; end
            mseu_pkg::OP_MFLO: begin wr = 1; widx = fa; wval = lo_q; end
            default: ;
        endcase
        if (wr && widx != 0) begin
            gpr[widx] = wval;
            r.reg_write = 1'b1; r.reg_index = widx; r.reg_value = wval;
        end
        r.hi = hi_q; r.lo = lo_q;
        return r;
    endfunction

    // tvalid stays high after acceptance until the next word or an idle gap replaces it
    task automatic send_instr(logic [3:0] op, logic [4:0] fa, logic [4:0] fb, logic [15:0] fc);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tdata  <= {2'b00, fc, fb, fa, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(execute_instr(op, fa, fb, fc));
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_exec_result got, exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_exec_result'(m_axis_tdata[104:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp = pending_results.pop_front();
                if (got.reg_write != exp.reg_write)
                    $display("%0t: reg_write exp %0d got %0d", $time, exp.reg_write, got.reg_write);
                if (got.reg_index != exp.reg_index)
                    $display("%0t: reg_index exp %0d got %0d", $time, exp.reg_index, got.reg_index);
                if (got.reg_value != exp.reg_value)
                    $display("%0t: reg_value exp %h got %h", $time, exp.reg_value, got.reg_value);
                if (got.mem_write != exp.mem_write)
                    $display("%0t: mem_write exp %0d got %0d", $time, exp.mem_write, got.mem_write);
                if (got.hi != exp.hi)
                    $display("%0t: hi exp %h got %h", $time, exp.hi, got.hi);
                if (got.lo != exp.lo)
                    $display("%0t: lo exp %h got %h", $time, exp.lo, got.lo);
                if (got.status != exp.status)
                    $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                if (got != exp) errors++;
            end
        end
    end

    // result-side stalls in random bursts
    always @(negedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog; the post-reset memory clear is well inside the limit
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] rand_imm();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 40)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_instr(mseu_pkg::OP_ADDI, 0, 1, 16'h7fff);
        send_instr(mseu_pkg::OP_ADDI, 0, 2, 16'h8000);
        send_instr(mseu_pkg::OP_SLL,  1, 3, 16'd16);        // 0x7fff0000
        send_instr(mseu_pkg::OP_ADDI, 3, 3, 16'hffff);
        send_instr(mseu_pkg::OP_SLL,  3, 4, 16'hffe1);      // shift uses low five bits only
        send_instr(mseu_pkg::OP_ADD,  3, 3, 16'd5);         // add wraps
        send_instr(mseu_pkg::OP_SUB,  2, 1, 16'hffe6);      // destination from low bits
        send_instr(mseu_pkg::OP_AND,  1, 2, 16'd7);
        send_instr(mseu_pkg::OP_OR,   1, 2, 16'd8);
        send_instr(mseu_pkg::OP_XOR,  1, 2, 16'd9);
        send_instr(mseu_pkg::OP_SLT,  2, 1, 16'd10);
        send_instr(mseu_pkg::OP_SLT,  1, 2, 16'd11);
        send_instr(mseu_pkg::OP_SRL,  2, 12, 16'd31);       // logical: no sign fill
        send_instr(mseu_pkg::OP_ADDI, 0, 0, 16'h1234);      // write to zero dropped
        send_instr(mseu_pkg::OP_SW,   0, 4, 16'd1023);
        send_instr(mseu_pkg::OP_LW,   0, 13, 16'd1023);
        send_instr(mseu_pkg::OP_SW,   0, 4, 16'd1024);      // past the end
        send_instr(mseu_pkg::OP_LW,   2, 13, 16'd0);        // negative address
        send_instr(mseu_pkg::OP_MULT, 2, 2, 16'd0);
        send_instr(mseu_pkg::OP_MFHI, 14, 0, 16'd0);
        send_instr(mseu_pkg::OP_ADDI, 0, 15, 16'hffff);
        send_instr(mseu_pkg::OP_SLL,  15, 16, 16'd31);      // most negative value
        send_instr(mseu_pkg::OP_DIV,  16, 15, 16'd0);       // divide overflow
        send_instr(mseu_pkg::OP_DIV,  2, 0, 16'd0);         // divide by zero
        send_instr(mseu_pkg::OP_DIV,  4, 2, 16'd0);
        send_instr(mseu_pkg::OP_MFLO, 17, 0, 16'd0);
        send_instr(4'hf,              1, 2, 16'hffff);      // unused opcode
    endtask

    task automatic test_random(int n);
        logic [3:0] op;
        for (int i = 0; i < n; i++) begin
            if (i > n - 150) quiet = 1'b1;
            op = 4'($urandom_range(0, 15));
            if (op == mseu_pkg::OP_LW || op == mseu_pkg::OP_SW)
                // mostly base from register 0 so addresses land in range
                send_instr(op, ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0,
                           5'($urandom), ($urandom_range(0, 5) == 0) ? rand_imm()
                                        : 16'($urandom_range(0, MEMW - 1)));
            else if (op == mseu_pkg::OP_DIV && $urandom_range(0, 3) == 0)
                send_instr(op, 5'($urandom), 5'd0, 16'($urandom));
            else
                send_instr(op, 5'($urandom), 5'($urandom), rand_imm());
        end
    endtask

    initial begin
        errors = 0; idle_cycles = 0; quiet = 1'b0;
        for (int i = 0; i < mseu_pkg::NUM_REGS; i++) gpr[i] = '0;
        for (int i = 0; i < MEMW; i++) dmem[i] = '0;
        hi_q = '0; lo_q = '0;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1080);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
